>>> src/wrpm_pkg.sv
`timescale 1ns / 1ps

package wrpm_pkg;

  // Result field width and configuration register width
  localparam int OUT_W = 16;
  localparam int CFG_W = 16;

  // Window length after reset
  localparam logic [CFG_W-1:0] WIN_RESET = 16'd1600;

  // Status of the window queue, seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROOT,
    BK_DONE
  } bk_state_t;

endpackage

>>> src/wrpm_front.sv
`timescale 1ns / 1ps

module wrpm_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [wrpm_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [SAMPLE_BITS-1:0]              sample_in,
  input  wrpm_pkg::q_stat_t                   q_stat,
  output logic                                push,
  output logic [4*SAMPLE_BITS+3*COUNT_BITS-2:0] push_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int SQ_W  = 2 * SB - 1 + CB;
  localparam int DF_W  = SB + CB;
  localparam int CW_W  = wrpm_pkg::CFG_W;
  localparam int CMP_W = (CB > CW_W) ? CB : CW_W;

  logic [CW_W-1:0] win_r;
  logic            p_r,   p_nxt;
  logic [2*SB-1:0] sq_r;
  logic [SB-1:0]   ad_r;
  logic [SB-1:0]   mg_r;
  logic [SB-1:0]   prev_r;
  logic [SQ_W-1:0] ssq_r, ssq_nxt;
  logic [DF_W-1:0] sdf_r, sdf_nxt;
  logic [SB-1:0]   pk_r,  pk_nxt;
  logic [CB-1:0]   cnt_r, cnt_nxt;

  logic            accept;
  logic            proceed;
  logic            done;
  logic [SB-1:0]   mag_c;
  logic [SB:0]     dif_c;
  logic [SB-1:0]   ad_c;
  logic [2*SB-1:0] sq_c;
  logic [SQ_W-1:0] ssq_sum;
  logic [DF_W-1:0] sdf_sum;
  logic [SB-1:0]   pk_new;
  logic [CB-1:0]   cnt_inc;
  logic [CB-1:0]   n_c;
  logic [CW_W-1:0] win_eff;

  // Magnitude, square and edge of the incoming sample
  assign mag_c = sample_in[SB-1] ? SB'(~sample_in + 1'b1) : sample_in;
  assign dif_c = {sample_in[SB-1], sample_in} - {prev_r[SB-1], prev_r};
  assign ad_c  = dif_c[SB] ? SB'(~dif_c + 1'b1) : dif_c[SB-1:0];
  assign sq_c  = {{SB{1'b0}}, mag_c} * {{SB{1'b0}}, mag_c};

  // Accumulate the registered sample and test for the window end
  assign ssq_sum = ssq_r + SQ_W'(sq_r);
  assign sdf_sum = sdf_r + DF_W'(ad_r);
  assign pk_new  = (mg_r > pk_r) ? mg_r : pk_r;
  assign cnt_inc = cnt_r + 1'b1;
  assign win_eff = (win_r == '0) ? CW_W'(1) : win_r;
  assign done    = (cnt_inc == '0) || (CMP_W'(cnt_inc) >= CMP_W'(win_eff));
  assign n_c     = (cnt_inc == '0) ? CB'(1) : cnt_inc;

  // Hold the sample stage while a finished window waits for queue space
  assign proceed   = p_r && !(done && q_stat.full);
  assign in_tready = !(p_r && done && q_stat.full);
  assign accept    = in_tvalid && in_tready;
  assign push      = proceed && done;
  assign push_data = {n_c, pk_new, sdf_sum, ssq_sum};

  always_comb begin
    p_nxt   = p_r;
    ssq_nxt = ssq_r;
    sdf_nxt = sdf_r;
    pk_nxt  = pk_r;
    cnt_nxt = cnt_r;
    if (proceed) begin
      p_nxt = 1'b0;
      if (done) begin
        ssq_nxt = '0;
        sdf_nxt = '0;
        pk_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        ssq_nxt = ssq_sum;
        sdf_nxt = sdf_sum;
        pk_nxt  = pk_new;
        cnt_nxt = cnt_inc;
      end
    end
    if (accept) begin
      p_nxt = 1'b1;
    end
  end

  // Control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= wrpm_pkg::WIN_RESET;
      p_r    <= 1'b0;
      prev_r <= '0;
      ssq_r  <= '0;
      sdf_r  <= '0;
      pk_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (accept) begin
        prev_r <= sample_in;
      end
      p_r   <= p_nxt;
      ssq_r <= ssq_nxt;
      sdf_r <= sdf_nxt;
      pk_r  <= pk_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Sample stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r <= sq_c;
      ad_r <= ad_c;
      mg_r <= mag_c;
    end
  end

endmodule

>>> src/wrpm_queue.sv
`timescale 1ns / 1ps

module wrpm_queue #(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      push_data,
  input  logic              pop,
  output logic [W-1:0]      head,
  output wrpm_pkg::q_stat_t q_stat
);

  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   fill_r;
  logic         do_push;
  logic         do_pop;

  assign q_stat.full  = (fill_r == 2'd2);
  assign q_stat.empty = (fill_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = ent_r[rp_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  // Store a finished window
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

>>> src/wrpm_back.sv
`timescale 1ns / 1ps

module wrpm_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [4*SAMPLE_BITS+3*COUNT_BITS-2:0] head,
  input  wrpm_pkg::q_stat_t                     q_stat,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [3*wrpm_pkg::OUT_W-1:0]          out_tdata
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int SQ_W = 2 * SB - 1 + CB;
  localparam int DF_W = SB + CB;
  localparam int OW   = wrpm_pkg::OUT_W;
  localparam int ST_W = $clog2(SQ_W);

  wrpm_pkg::bk_state_t state_r, state_nxt;

  logic [ST_W-1:0] step_r, step_nxt;
  logic [CB-1:0]   n_r,    n_nxt;
  logic [SB-1:0]   pk_r,   pk_nxt;
  logic [SQ_W-1:0] dq_r,   dq_nxt;
  logic [SQ_W-1:0] dd_r,   dd_nxt;
  logic [CB-1:0]   rs_r,   rs_nxt;
  logic [CB-1:0]   rd_r,   rd_nxt;
  logic [2*SB-1:0] rad_r,  rad_nxt;
  logic [SB-1:0]   root_r, root_nxt;
  logic [SB:0]     rem_r,  rem_nxt;
  logic            ov_r,   ov_nxt;
  logic            load_out;
  logic [3*OW-1:0] od_r;

  logic [CB:0]     rs_sh, rd_sh, n_ext;
  logic            rs_ge, rd_ge;
  logic [CB:0]     rs_dif, rd_dif;
  logic [SB+1:0]   rt, trial, rt_dif;
  logic            rt_ge;

  // One quotient bit per cycle for both divisions by the window count
  assign n_ext  = {1'b0, n_r};
  assign rs_sh  = {rs_r, dq_r[SQ_W-1]};
  assign rd_sh  = {rd_r, dd_r[SQ_W-1]};
  assign rs_ge  = (rs_sh >= n_ext);
  assign rd_ge  = (rd_sh >= n_ext);
  assign rs_dif = rs_sh - n_ext;
  assign rd_dif = rd_sh - n_ext;

  // One root bit per cycle, two radicand bits in
  assign rt     = {rem_r[SB-1:0], rad_r[2*SB-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign rt_ge  = (rt >= trial);
  assign rt_dif = rt - trial;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    n_nxt     = n_r;
    pk_nxt    = pk_r;
    dq_nxt    = dq_r;
    dd_nxt    = dd_r;
    rs_nxt    = rs_r;
    rd_nxt    = rd_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    ov_nxt    = ov_r && !out_tready;
    case (state_r)
      wrpm_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          dq_nxt    = head[SQ_W-1:0];
          dd_nxt    = SQ_W'(head[SQ_W +: DF_W]);
          pk_nxt    = head[SQ_W+DF_W +: SB];
          n_nxt     = head[SQ_W+DF_W+SB +: CB];
          rs_nxt    = '0;
          rd_nxt    = '0;
          step_nxt  = ST_W'(SQ_W - 1);
          state_nxt = wrpm_pkg::BK_DIV;
        end
      end
      wrpm_pkg::BK_DIV: begin
        rs_nxt = rs_ge ? rs_dif[CB-1:0] : rs_sh[CB-1:0];
        rd_nxt = rd_ge ? rd_dif[CB-1:0] : rd_sh[CB-1:0];
        dq_nxt = {dq_r[SQ_W-2:0], rs_ge};
        dd_nxt = {dd_r[SQ_W-2:0], rd_ge};
        if (step_r == '0) begin
          rad_nxt   = dq_nxt[2*SB-1:0];
          root_nxt  = '0;
          rem_nxt   = '0;
          step_nxt  = ST_W'(SB - 1);
          state_nxt = wrpm_pkg::BK_ROOT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      wrpm_pkg::BK_ROOT: begin
        rem_nxt  = rt_ge ? rt_dif[SB:0] : rt[SB:0];
        root_nxt = {root_r[SB-2:0], rt_ge};
        rad_nxt  = rad_r << 2;
        if (step_r == '0) begin
          state_nxt = wrpm_pkg::BK_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      wrpm_pkg::BK_DONE: begin
        if (!ov_r || out_tready) begin
          load_out  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = wrpm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = wrpm_pkg::BK_IDLE;
      end
    endcase
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrpm_pkg::BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    n_r    <= n_nxt;
    pk_r   <= pk_nxt;
    dq_r   <= dq_nxt;
    dd_r   <= dd_nxt;
    rs_r   <= rs_nxt;
    rd_r   <= rd_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    if (load_out) begin
      od_r <= {OW'(dd_r), OW'(pk_r), OW'(root_r)};
    end
  end

endmodule

>>> src/windowed_rms_peak_meter.sv
`timescale 1ns / 1ps
// Channel | Direction | Transfer content
// in_     | slave     | in_tdata: sample_in (SAMPLE_BITS, signed), zero padded to bytes
// out_    | master    | out_tdata: rms_level [15:0], peak_level [31:16], mean_edge [47:32]
// cfg_    | write     | cfg_wr_data: window_length (16 bits, 0 acts as 1)
//
// Input: one sample per cycle while in_tready is high; each sample is squared
// in one stage and accumulated in the next.
// A finished window enters a two-entry queue; the back end then runs it
// through its bit-serial dividers and its bit-serial root, one window at a
// time. Windows that close faster than the back end finishes a result stall
// the input once the queue is full.
// Reset is synchronous, active low; no clearing pass is needed.

module windowed_rms_peak_meter #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [wrpm_pkg::CFG_W-1:0]            cfg_wr_data,   // window_length
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,      // sample_in
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [3*wrpm_pkg::OUT_W-1:0]          out_tdata      // rms_level, peak_level, mean_edge
);

  localparam int E_W = 4 * SAMPLE_BITS + 3 * COUNT_BITS - 1;

  logic              push;
  logic              pop;
  logic [E_W-1:0]    push_data;
  logic [E_W-1:0]    head;
  wrpm_pkg::q_stat_t q_stat;

  // Accumulate samples and close windows
  wrpm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .sample_in   (in_tdata[SAMPLE_BITS-1:0]),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  // Buffer finished windows
  wrpm_queue #(
    .W (E_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Divide, take the root and present the result
  wrpm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/wrpm_checker.sv
`timescale 1ns / 1ps

module wrpm_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [3*wrpm_pkg::OUT_W-1:0] out_tdata
);

  localparam int OW = wrpm_pkg::OUT_W;
  localparam logic [OW:0] PK_MAX = (OW + 1)'(1) << (SAMPLE_BITS - 1);
  localparam bit NARROW = (SAMPLE_BITS <= OW);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before transfer");

  // Peak never exceeds full scale
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && NARROW |-> {1'b0, out_tdata[2*OW-1:OW]} <= PK_MAX)
    else $error("peak level beyond full scale");

  // RMS of a window never exceeds its peak
  a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && NARROW |-> out_tdata[OW-1:0] <= out_tdata[2*OW-1:OW])
    else $error("rms level above peak level");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind windowed_rms_peak_meter wrpm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wrpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/level_meter_check.sv
`timescale 1ns / 1ps

module level_meter_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [wrpm_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [15:0]               in_tdata,     // sample_in
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [47:0]               out_tdata,    // rms_level, peak_level, mean_edge
  output int                        pending_levels,
  output int                        fail_count
);

  // One window result, laid out as on out_tdata (rms in the lowest bits)
  typedef struct packed {
    logic [wrpm_pkg::OUT_W-1:0] edge_mean;
    logic [wrpm_pkg::OUT_W-1:0] peak;
    logic [wrpm_pkg::OUT_W-1:0] rms;
  } levels_t;

  // Shadow of the meter state
  logic [wrpm_pkg::CFG_W-1:0] win_len;
  logic [45:0]        sq_sum;
  logic [31:0]        diff_sum;
  logic [15:0]        peak_abs;
  logic [15:0]        n_seen;
  logic signed [15:0] last_sample;
  levels_t            level_q[$];

  initial fail_count = 0;
  initial pending_levels = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Integer square root, rounded down, built one result bit at a time
  function automatic logic [15:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r[15:0];
  endfunction

  // Fold one sample into the window; queue the levels when it closes
  task automatic absorb_sample(input logic [15:0] raw);
    int         sv;
    int         av;
    int         dv;
    logic [15:0] target;
    logic [63:0] n;
    levels_t    lv;
    sv = int'($signed(raw));
    av = (sv < 0) ? -sv : sv;
    dv = sv - int'(last_sample);
    dv = (dv < 0) ? -dv : dv;
    sq_sum = sq_sum + 46'(av * av);
    if (av > int'(peak_abs)) peak_abs = 16'(av);
    diff_sum = diff_sum + 32'(dv);
    last_sample = $signed(raw);
    n_seen = n_seen + 16'd1;
    // a zero length acts as one
    target = (win_len == '0) ? 16'd1 : win_len;
    if (n_seen != 16'd0 && n_seen < target) return;
    n = (n_seen == 16'd0) ? 64'd1 : 64'(n_seen);
    lv.rms = floor_root(64'(sq_sum) / n);
    lv.peak = peak_abs;
    lv.edge_mean = 16'(64'(diff_sum) / n);
    level_q.push_back(lv);
    sq_sum = '0;
    diff_sum = '0;
    peak_abs = '0;
    n_seen = '0;
  endtask

  // Watch register writes and both channels at every edge
  always @(posedge clk) begin : watch
    levels_t got;
    levels_t want;
    if (!rst_n) begin
      win_len = wrpm_pkg::WIN_RESET;
      sq_sum = '0;
      diff_sum = '0;
      peak_abs = '0;
      n_seen = '0;
      last_sample = '0;
      level_q.delete();
    end else begin
      if (cfg_wr_en) win_len = cfg_wr_data;
      // compare a result transfer with the oldest expectation
      if (out_tvalid && out_tready) begin
        got = levels_t'(out_tdata);
        if (level_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tdata %h", out_tdata));
        end else begin
          want = level_q.pop_front();
          if (got.rms !== want.rms)
            report_mismatch($sformatf("rms_level %0d, expected %0d", got.rms, want.rms));
          if (got.peak !== want.peak)
            report_mismatch($sformatf("peak_level %0d, expected %0d", got.peak, want.peak));
          if (got.edge_mean !== want.edge_mean)
            report_mismatch($sformatf("mean_edge %0d, expected %0d",
                                      got.edge_mean, want.edge_mean));
        end
      end
      if (in_tvalid && in_tready) absorb_sample(in_tdata);
    end
    pending_levels <= level_q.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int LONG_HOLD     = 600;
  localparam int RANDOM_ITEMS  = 1800;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [wrpm_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;     // sample_in
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;         // rms_level, peak_level, mean_edge
  int               pending_levels;
  int               fail_count;
  int               cycles = 0;
  logic             hold_request = 1'b0;
  logic             tx_burst = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  windowed_rms_peak_meter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  level_meter_check level_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .pending_levels (pending_levels),
    .fail_count     (fail_count)
  );

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, burst stretches, one long hold-off on request
  initial begin : rx_side
    int   gap;
    logic rx_burst;
    rx_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send_sample(input logic [15:0] v);
    int gap;
    if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= v;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait for every expected window, then let the pipeline settle
  task automatic drain_levels();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_levels != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [wrpm_pkg::CFG_W-1:0] v);
    drain_levels();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly full-range samples, some extremes, some near silence
  function automatic logic [15:0] pick_sample();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) return 16'($urandom_range(0, 65535));
    if (mode <= 7) begin
      case ($urandom_range(0, 4))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        3:       return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom_range(0, 128) - 64);
  endfunction

  initial begin : stimulus
    int sent;
    int win;
    int eff;
    int n_items;
    int pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default length: first difference is against zero, then shorten the
    // window below the count so the next sample closes it
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hffff);
    send_sample(16'h4000);
    send_sample(16'hc000);
    set_window(16'd3);
    send_sample(16'h1234);

    // Zero length acts as one; full-scale negative and full swings
    set_window(16'd0);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);

    set_window(16'd1);
    send_sample(16'h7fff);
    send_sample(16'hffff);

    // Longest window, cut short after a few samples
    set_window(16'hffff);
    repeat (4) send_sample(pick_sample());
    set_window(16'd2);
    send_sample(pick_sample());

    // Alternating full scale: largest mean edge
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h8000);

    // Back-pressure: hold the result side while samples keep coming
    set_window(16'd1);
    hold_request = 1'b1;
    tx_burst = 1'b1;
    repeat (40) send_sample(pick_sample());

    // Random phases with varied window lengths and partial windows
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) win = 0;
      else if (pick == 1) win = 1;
      else if (pick == 2) win = $urandom_range(60, 200);
      else if (pick == 3) win = 65535;
      else win = $urandom_range(2, 24);
      set_window(16'(win));
      eff = (win == 0) ? 1 : win;
      if (win == 65535) n_items = $urandom_range(1, 30);
      else if (win >= 60) n_items = $urandom_range(eff, 2 * eff);
      else n_items = $urandom_range(1, 4 * eff);
      repeat (n_items) send_sample(pick_sample());
      sent += n_items;
    end

    drain_levels();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
